>>> rtl/swam_pkg.sv
// Shared types and constants for the sliding window anagram matcher.
// Used by the front stage, the item queue, the back stage and the top level.
package swam_pkg;

   localparam int LETTER_W    = 5;
   localparam int INDEX_W     = 32;
   localparam int FUNC_W      = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // function codes on the request channel
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PATTERN = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_PATTERN,
      OP_TEXT
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [LETTER_W-1:0] letter;
   } item_type;

endpackage

>>> rtl/swam_front.sv
// Front stage: accepts request items, drops illegal ones, decodes the rest.
// Depends on swam_pkg; feeds swam_queue.
module swam_front import swam_pkg::*; #(
   parameter int ALPHABET = 26
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                q_full,
   output logic                q_push,
   output item_type            q_item
);

   logic     f_valid_ff, f_valid_in;
   item_type f_item_ff,  f_item_in;
   logic     legal;
   logic     in_alpha;
   logic     advance;

   assign in_alpha = 32'(req_letter) < ALPHABET;

   always_comb begin
      legal        = 1'b0;
      f_item_in.op = OP_CLEAR;
      unique case (req_func)
         FUNC_CLEAR: begin
            legal        = 1'b1;
            f_item_in.op = OP_CLEAR;
         end
         FUNC_PATTERN: begin
            legal        = in_alpha;
            f_item_in.op = OP_PATTERN;
         end
         FUNC_TEXT: begin
            legal        = in_alpha;
            f_item_in.op = OP_TEXT;
         end
         default: legal = 1'b0;
      endcase
      f_item_in.letter = req_letter;
   end

   assign advance    = !f_valid_ff || !q_full;
   assign req_stall  = f_valid_ff && q_full;
   assign f_valid_in = advance ? (req_valid && legal) : f_valid_ff;
   assign q_push     = f_valid_ff && !q_full;
   assign q_item     = f_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      if (advance) begin
         f_item_ff <= f_item_in;
      end
   end

endmodule

>>> rtl/swam_queue.sv
// Short item queue between the front and back stages.
// Depends on swam_pkg.
module swam_queue import swam_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     valid,
   output item_type pop_item
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff,  count_in;

   assign full     = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign valid    = count_ff != '0;
   assign pop_item = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/swam_back.sv
// Back stage: per-letter count lanes, window ring memory and result register.
// Depends on swam_pkg; drains swam_queue.
module swam_back import swam_pkg::*; #(
   parameter int MAX_PATTERN = 32,
   parameter int ALPHABET    = 26
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_match,
   output logic [INDEX_W-1:0] rsp_start_index
);

   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [CW-1:0]       wcount_ff [ALPHABET];
   logic [CW-1:0]       wcount_in [ALPHABET];
   logic [CW-1:0]       pcount_ff [ALPHABET];
   logic [CW-1:0]       pcount_in [ALPHABET];
   logic [ALPHABET-1:0] diff_in;
   logic [CW-1:0]       plen_ff,   plen_in;
   logic [CW-1:0]       fill_ff,   fill_in;
   logic [PW-1:0]       ptr_ff,    ptr_in;
   logic [INDEX_W-1:0]  tcount_ff, tcount_in;
   logic                begun_ff,  begun_in;

   logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];
   logic [LETTER_W-1:0] old_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                match_ff;
   logic [INDEX_W-1:0]  start_ff;

   logic fire;
   logic produce;
   logic do_write;
   logic full;
   logic old_ok;
   logic inc;
   logic dec;

   assign fire   = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop  = fire;
   assign full   = fill_ff == plen_ff;
   assign old_ok = 32'(old_ff) < ALPHABET;

   always_comb begin
      plen_in   = plen_ff;
      fill_in   = fill_ff;
      ptr_in    = ptr_ff;
      tcount_in = tcount_ff;
      begun_in  = begun_ff;
      do_write  = 1'b0;
      produce   = 1'b0;
      inc       = 1'b0;
      dec       = 1'b0;
      for (int i = 0; i < ALPHABET; i++) begin
         wcount_in[i] = wcount_ff[i];
         pcount_in[i] = pcount_ff[i];
      end
      if (fire) begin
         unique case (q_item.op)
            OP_CLEAR: begin
               plen_in   = '0;
               fill_in   = '0;
               ptr_in    = '0;
               tcount_in = '0;
               begun_in  = 1'b0;
               for (int i = 0; i < ALPHABET; i++) begin
                  wcount_in[i] = '0;
                  pcount_in[i] = '0;
               end
            end
            OP_PATTERN: begin
               if (!begun_ff && 32'(plen_ff) < MAX_PATTERN) begin
                  plen_in = plen_ff + 1'b1;
                  for (int i = 0; i < ALPHABET; i++) begin
                     if (32'(q_item.letter) == i) begin
                        pcount_in[i] = pcount_ff[i] + 1'b1;
                     end
                  end
               end
            end
            OP_TEXT: begin
               begun_in  = 1'b1;
               tcount_in = tcount_ff + 1'b1;
               if (plen_ff != '0) begin
                  // the oldest letter leaves only once the window is full
                  for (int i = 0; i < ALPHABET; i++) begin
                     inc = 32'(q_item.letter) == i;
                     dec = full && old_ok && (32'(old_ff) == i);
                     if (inc && !dec) begin
                        wcount_in[i] = wcount_ff[i] + 1'b1;
                     end else if (dec && !inc) begin
                        wcount_in[i] = wcount_ff[i] - 1'b1;
                     end
                  end
                  do_write = 1'b1;
                  ptr_in   = (CW'(ptr_ff) + 1'b1 == plen_ff) ? '0 : ptr_ff + 1'b1;
                  fill_in  = full ? fill_ff : fill_ff + 1'b1;
                  produce  = full || (fill_ff + 1'b1 == plen_ff);
               end
            end
            default: ;
         endcase
      end
      for (int i = 0; i < ALPHABET; i++) begin
         diff_in[i] = wcount_in[i] != pcount_in[i];
      end
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || (fire && produce);

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         tcount_ff    <= '0;
         begun_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ALPHABET; i++) begin
            wcount_ff[i] <= '0;
            pcount_ff[i] <= '0;
         end
      end else begin
         plen_ff      <= plen_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         tcount_ff    <= tcount_in;
         begun_ff     <= begun_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ALPHABET; i++) begin
            wcount_ff[i] <= wcount_in[i];
            pcount_ff[i] <= pcount_in[i];
         end
      end
      if (fire && produce) begin
         match_ff <= ~|diff_in;
         start_ff <= tcount_ff - INDEX_W'(plen_ff) + 1'b1;
      end
   end

   // ring memory: read ahead at the next slot, bypass when it is the one being written
   always_ff @(posedge clock) begin
      if (do_write) begin
         ring_mem[ptr_ff] <= q_item.letter;
      end
      if (do_write && ptr_ff == ptr_in) begin
         old_ff <= q_item.letter;
      end else begin
         old_ff <= ring_mem[ptr_in];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match       = match_ff;
   assign rsp_start_index = start_ff;

endmodule

>>> rtl/sliding_window_anagram_match.sv
// Sliding window anagram matcher: one request item (clear, pattern letter or
// text letter) is taken per clock cycle while req_stall is low. An item
// passes a decode register, a four-entry queue and the execute stage, whose
// result register drives the response channel. The execute stage finishes
// one item per cycle; the window ring memory is read one item ahead with a
// bypass, and the per-letter count lanes update in parallel.
// While a result waits under rsp_stall the execute stage holds, and the
// queue plus the decode register absorb up to five items before req_stall.
// Top level; depends on swam_pkg, swam_front, swam_queue and swam_back.
module sliding_window_anagram_match import swam_pkg::*; #(
   parameter int MAX_PATTERN = 32,
   parameter int ALPHABET    = 26
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [LETTER_W-1:0] req_letter,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_match,
   output logic [INDEX_W-1:0]  rsp_start_index
);

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_valid;
   item_type push_item;
   item_type pop_item;

   swam_front #(
      .ALPHABET(ALPHABET)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .req_letter(req_letter),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   swam_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_item(push_item),
      .pop      (q_pop),
      .full     (q_full),
      .valid    (q_valid),
      .pop_item (pop_item)
   );

   swam_back #(
      .MAX_PATTERN(MAX_PATTERN),
      .ALPHABET   (ALPHABET)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_match      (rsp_match),
      .rsp_start_index(rsp_start_index)
   );

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule
